// ===== rtl/core/bpa_pkg.sv =====
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared constants, codes and types of the bitmap page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

    localparam int BPA_PAGE_COUNT = 65536;
    localparam int PAGE_SHIFT     = 12;
    localparam int WORD_BITS      = 64;
    localparam int CHUNK_BITS     = 8;
    localparam int ADDR_W         = 28;
    localparam int ADDR_PAGE_W    = ADDR_W - PAGE_SHIFT;
    localparam int INDEX_W        = 16;
    localparam int COUNT_W        = 17;
    localparam int ALIGN_W        = 5;

    typedef enum logic [1:0] {
        KIND_ALLOC   = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_RESERVE = 2'd2,
        KIND_QUERY   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_RUN     = 2'd1,
        ST_ZERO_COUNT = 2'd2,
        ST_PAST_END   = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_AL_RD,
        S_AL_EVAL,
        S_MK_RD,
        S_MK_WR,
        S_Q_RD,
        S_Q_EVAL,
        S_RESP
    } t_state;

endpackage

// ===== rtl/core/bpa_map_ram.sv =====
// ----------------------------------------------------------------------------
// bpa_map_ram
// Single-port used-bit map, one 64-bit word per address, registered read.
// ----------------------------------------------------------------------------
module bpa_map_ram import bpa_pkg::*; #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic                 i_re,
    input  logic [AW-1:0]        i_addr,
    input  logic [WORD_BITS-1:0] i_wdata,
    output logic [WORD_BITS-1:0] o_rdata
);

    logic [WORD_BITS-1:0] r_mem [DEPTH];
    logic [WORD_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/bpa_run_step.sv =====
// ----------------------------------------------------------------------------
// bpa_run_step
// Free-run tracker: advances the first-fit search over one 8-page chunk, or
// over a whole word at once when the word is all used or all free.
// ----------------------------------------------------------------------------
module bpa_run_step import bpa_pkg::*; #(
    parameter int WAW = 10,
    parameter int PGW = 16,
    parameter int RW  = 18
) (
    input  logic [WORD_BITS-1:0] i_data,
    input  logic [2:0]           i_chunk,
    input  logic [WAW-1:0]       i_word,
    input  logic [RW-1:0]        i_run,
    input  logic [PGW-1:0]       i_start,
    input  logic [PGW-1:0]       i_amask,
    input  logic [RW-1:0]        i_count,
    output logic [RW-1:0]        o_run,
    output logic [PGW-1:0]       o_start,
    output logic                 o_found,
    output logic                 o_last
);

    always_comb begin
        logic [CHUNK_BITS-1:0] bits;
        logic [PGW-1:0]        p;
        logic [RW-1:0]         run;
        logic [PGW-1:0]        start;
        logic                  stop;

        bits  = i_data[i_chunk*CHUNK_BITS +: CHUNK_BITS];
        run   = i_run;
        start = i_start;
        stop  = 1'b0;
        p     = {i_word, 6'd0};

        if (&i_data) begin
            run = '0;
            o_last = 1'b1;
        end else if (i_data == '0) begin
            // whole word free: extend the run or open one at the word start if aligned
            if (run != '0) begin
                run = run + RW'(WORD_BITS);
            end else if ((p & i_amask) == '0) begin
                start = p;
                run   = RW'(WORD_BITS);
            end
            stop   = (run != '0) && (run >= i_count);
            o_last = 1'b1;
        end else begin
            for (int k = 0; k < CHUNK_BITS; k++) begin
                p = {i_word, i_chunk, 3'(k)};
                if (!stop) begin
                    if (bits[k]) begin
                        run = '0;
                    end else if (run != '0 || (p & i_amask) == '0) begin
                        if (run == '0) begin
                            start = p;
                        end
                        run = run + RW'(1);
                        if (run == i_count) begin
                            stop = 1'b1;
                        end
                    end
                end
            end
            o_last = stop || (i_chunk == 3'd7);
        end

        o_run   = run;
        o_start = start;
        o_found = stop;
    end

endmodule

// ===== rtl/core/bpa_word_mask.sv =====
// ----------------------------------------------------------------------------
// bpa_word_mask
// Bit mask of the pages of one map word that fall inside a page range.
// ----------------------------------------------------------------------------
module bpa_word_mask import bpa_pkg::*; #(
    parameter int WAW = 10,
    parameter int PGW = 16
) (
    input  logic [WAW-1:0]       i_word,
    input  logic [PGW-1:0]       i_lo,
    input  logic [PGW-1:0]       i_hi,
    output logic [WORD_BITS-1:0] o_mask
);

    logic [5:0] lo_bit;
    logic [5:0] hi_bit;

    always_comb begin
        lo_bit = (i_word == i_lo[PGW-1:6]) ? i_lo[5:0] : 6'd0;
        hi_bit = (i_word == i_hi[PGW-1:6]) ? i_hi[5:0] : 6'd63;
        o_mask = ({WORD_BITS{1'b1}} << lo_bit) & ({WORD_BITS{1'b1}} >> (6'd63 - hi_bit));
    end

endmodule

// ===== rtl/core/bitmap_page_allocator_top.sv =====
// ----------------------------------------------------------------------------
// bitmap_page_allocator_top
// First-fit bitmap page frame allocator with aligned allocation.
// ----------------------------------------------------------------------------
// One request at a time: the request port is ready only while the sequencer
// idles, and a finished response waits in its own output register so the
// next request can be taken meanwhile. After reset the map is swept to
// "all used" word by word through the single RAM port before the first
// request is accepted. An allocate scan reads each word it visits and
// evaluates it whole when it is all used or all free, or one 8-page chunk
// at a time when it is mixed, then reads and writes each word it marks.
// Release and reserve read and write each word the range touches, a query
// reads one word and evaluates it, and requests failing a count or range
// check go straight to the response; each then loads the response register,
// waiting while that register is full and not being drained.
// ----------------------------------------------------------------------------
module bitmap_page_allocator_top import bpa_pkg::*; #(
    parameter int PAGE_COUNT = BPA_PAGE_COUNT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    output logic               o_req_ready,
    input  logic [1:0]         i_kind,
    input  logic [INDEX_W-1:0] i_page_index,
    input  logic [COUNT_W-1:0] i_page_count,
    input  logic [ALIGN_W-1:0] i_align_log2,
    output logic               o_rsp_valid,
    input  logic               i_rsp_ready,
    output logic [1:0]         o_status,
    output logic [ADDR_W-1:0]  o_page_address,
    output logic               o_page_used
);

    localparam int MAP_WORDS = (PAGE_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int WAW       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int PGW       = WAW + 6;
    localparam int RW        = ((PGW > COUNT_W) ? PGW : COUNT_W) + 1;
    localparam int LAST_BITS = PAGE_COUNT - (MAP_WORDS - 1) * WORD_BITS;
    localparam logic [WORD_BITS-1:0] TAIL_MASK =
        (LAST_BITS == WORD_BITS) ? {WORD_BITS{1'b1}}
                                 : ((WORD_BITS'(1) << LAST_BITS) - WORD_BITS'(1));
    localparam logic [WAW-1:0] LAST_WORD = WAW'(MAP_WORDS - 1);

    t_state              r_state, n_state;
    logic [WAW-1:0]      r_word, n_word;
    logic [2:0]          r_chunk, n_chunk;
    logic [RW-1:0]       r_run, n_run;
    logic [RW-1:0]       r_count, n_count;
    logic [PGW-1:0]      r_lo, n_lo;
    logic [PGW-1:0]      r_hi, n_hi;
    logic [PGW-1:0]      r_amask, n_amask;
    logic                r_set, n_set;
    t_status             r_res_status, n_res_status;
    logic [ADDR_W-1:0]   r_res_addr, n_res_addr;
    logic                r_res_used, n_res_used;
    logic                r_rsp_valid, n_rsp_valid;
    t_status             r_out_status, n_out_status;
    logic [ADDR_W-1:0]   r_out_addr, n_out_addr;
    logic                r_out_used, n_out_used;

    logic                 mem_we;
    logic                 mem_re;
    logic [WAW-1:0]       mem_addr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic [WORD_BITS-1:0] mem_rdata;
    logic [WORD_BITS-1:0] scan_data;
    logic [WORD_BITS-1:0] range_mask;
    logic [RW-1:0]        step_run;
    logic [PGW-1:0]       step_start;
    logic                 step_found;
    logic                 step_last;

    bpa_map_ram #(
        .DEPTH (MAP_WORDS),
        .AW    (WAW)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_re    (mem_re),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    // pages past the end of the map read as used
    assign scan_data = mem_rdata | ((r_word == LAST_WORD) ? ~TAIL_MASK : '0);

    bpa_run_step #(
        .WAW (WAW),
        .PGW (PGW),
        .RW  (RW)
    ) u_run_step (
        .i_data  (scan_data),
        .i_chunk (r_chunk),
        .i_word  (r_word),
        .i_run   (r_run),
        .i_start (r_lo),
        .i_amask (r_amask),
        .i_count (r_count),
        .o_run   (step_run),
        .o_start (step_start),
        .o_found (step_found),
        .o_last  (step_last)
    );

    bpa_word_mask #(
        .WAW (WAW),
        .PGW (PGW)
    ) u_word_mask (
        .i_word (r_word),
        .i_lo   (r_lo),
        .i_hi   (r_hi),
        .o_mask (range_mask)
    );

    always_comb begin
        logic [RW-1:0]      range_end;
        logic [ALIGN_W-1:0] shift;

        n_state      = r_state;
        n_word       = r_word;
        n_chunk      = r_chunk;
        n_run        = r_run;
        n_count      = r_count;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_amask      = r_amask;
        n_set        = r_set;
        n_res_status = r_res_status;
        n_res_addr   = r_res_addr;
        n_res_used   = r_res_used;
        n_rsp_valid  = r_rsp_valid && !i_rsp_ready;
        n_out_status = r_out_status;
        n_out_addr   = r_out_addr;
        n_out_used   = r_out_used;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_addr     = r_word;
        mem_wdata    = {WORD_BITS{1'b1}};

        range_end = RW'(i_page_index) + RW'(i_page_count);
        shift     = (i_align_log2 > ALIGN_W'(PAGE_SHIFT))
                  ? i_align_log2 - ALIGN_W'(PAGE_SHIFT) : '0;

        unique case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                n_word = r_word + WAW'(1);
                if (r_word == LAST_WORD) begin
                    n_word  = '0;
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                if (i_req_valid) begin
                    n_res_status = ST_OK;
                    n_res_addr   = '0;
                    n_res_used   = 1'b0;
                    n_count      = RW'(i_page_count);
                    n_lo         = PGW'(i_page_index);
                    n_hi         = PGW'(range_end - RW'(1));
                    n_word       = n_lo[PGW-1:6];
                    n_state      = S_RESP;
                    for (int i = 0; i < PGW; i++) begin
                        n_amask[i] = (i < int'(shift));
                    end
                    unique case (t_kind'(i_kind))
                        KIND_ALLOC: begin
                            n_set = 1'b1;
                            if (i_page_count == '0) begin
                                n_res_status = ST_ZERO_COUNT;
                            end else if (RW'(i_page_count) > RW'(PAGE_COUNT)) begin
                                n_res_status = ST_NO_RUN;
                            end else begin
                                n_word  = '0;
                                n_chunk = '0;
                                n_run   = '0;
                                n_state = S_AL_RD;
                            end
                        end
                        KIND_RELEASE, KIND_RESERVE: begin
                            n_set = (t_kind'(i_kind) == KIND_RESERVE);
                            if (i_page_count == '0) begin
                                n_res_status = ST_ZERO_COUNT;
                            end else if (range_end > RW'(PAGE_COUNT)) begin
                                n_res_status = ST_PAST_END;
                            end else begin
                                n_state = S_MK_RD;
                            end
                        end
                        KIND_QUERY: begin
                            if (RW'(i_page_index) >= RW'(PAGE_COUNT)) begin
                                n_res_status = ST_PAST_END;
                            end else begin
                                n_state = S_Q_RD;
                            end
                        end
                        default: n_state = S_RESP;
                    endcase
                end
            end

            S_AL_RD: begin
                mem_re  = 1'b1;
                n_state = S_AL_EVAL;
            end

            S_AL_EVAL: begin
                n_run = step_run;
                n_lo  = step_start;
                if (step_found) begin
                    // mark the run, starting at its first word
                    n_hi       = PGW'(RW'(step_start) + r_count - RW'(1));
                    n_word     = step_start[PGW-1:6];
                    n_res_addr = {ADDR_PAGE_W'(step_start), {PAGE_SHIFT{1'b0}}};
                    n_state    = S_MK_RD;
                end else if (step_last) begin
                    n_chunk = '0;
                    if (r_word == LAST_WORD) begin
                        n_res_status = ST_NO_RUN;
                        n_state      = S_RESP;
                    end else begin
                        n_word  = r_word + WAW'(1);
                        n_state = S_AL_RD;
                    end
                end else begin
                    n_chunk = r_chunk + 3'd1;
                end
            end

            S_MK_RD: begin
                mem_re  = 1'b1;
                n_state = S_MK_WR;
            end

            S_MK_WR: begin
                mem_we    = 1'b1;
                mem_wdata = r_set ? (mem_rdata | range_mask) : (mem_rdata & ~range_mask);
                if (r_word == r_hi[PGW-1:6]) begin
                    n_state = S_RESP;
                end else begin
                    n_word  = r_word + WAW'(1);
                    n_state = S_MK_RD;
                end
            end

            S_Q_RD: begin
                mem_re  = 1'b1;
                n_state = S_Q_EVAL;
            end

            S_Q_EVAL: begin
                n_res_used = mem_rdata[r_lo[5:0]];
                n_state    = S_RESP;
            end

            S_RESP: begin
                // hold until the response register is free or being drained
                if (!r_rsp_valid || i_rsp_ready) begin
                    n_rsp_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_addr   = r_res_addr;
                    n_out_used   = r_res_used;
                    n_state      = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_word      <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_word      <= n_word;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chunk      <= n_chunk;
        r_run        <= n_run;
        r_count      <= n_count;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_amask      <= n_amask;
        r_set        <= n_set;
        r_res_status <= n_res_status;
        r_res_addr   <= n_res_addr;
        r_res_used   <= n_res_used;
        r_out_status <= n_out_status;
        r_out_addr   <= n_out_addr;
        r_out_used   <= n_out_used;
    end

    assign o_req_ready    = (r_state == S_IDLE);
    assign o_rsp_valid    = r_rsp_valid;
    assign o_status       = r_out_status;
    assign o_page_address = r_out_addr;
    assign o_page_used    = r_out_used;

endmodule

// ===== sim/page_alloc_checker.sv =====
// ----------------------------------------------------------------------------
// page_alloc_checker
// Watches both handshakes of the page allocator and keeps its own copy of the
// page map. Each accepted request is applied to that copy and its reply is
// queued; each accepted response is compared field by field against the
// oldest queued reply.
// ----------------------------------------------------------------------------
module page_alloc_checker import bpa_pkg::*; #(
    parameter int PAGES = BPA_PAGE_COUNT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    input  logic               i_req_ready,
    input  logic [1:0]         i_kind,
    input  logic [INDEX_W-1:0] i_page_index,
    input  logic [COUNT_W-1:0] i_page_count,
    input  logic [ALIGN_W-1:0] i_align_log2,
    input  logic               i_rsp_valid,
    input  logic               i_rsp_ready,
    input  logic [1:0]         i_status,
    input  logic [ADDR_W-1:0]  i_page_address,
    input  logic               i_page_used,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_checked,
    output int                 o_placed
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAP_WORDS = (PAGES + WORD_BITS - 1) / WORD_BITS;

    typedef struct packed {
        t_status           status;
        logic [ADDR_W-1:0] address;
        logic              used;
    } page_reply_t;

    logic [WORD_BITS-1:0] page_map [MAP_WORDS];
    page_reply_t          expected_replies [$];
    int                   mismatches = 0;
    int                   n_issued   = 0;
    int                   n_answered = 0;
    int                   n_placed   = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = n_issued - n_answered;
    assign o_checked    = n_answered;
    assign o_placed     = n_placed;

    function automatic logic page_is_used(int page);
        return page_map[page / WORD_BITS][page % WORD_BITS];
    endfunction

    function automatic void mark_pages(int first, int count, logic used);
        for (int p = first; p < first + count; p++) begin
            page_map[p / WORD_BITS][p % WORD_BITS] = used;
        end
    endfunction

    // Apply one request to the mirrored map and return the reply it earns.
    function automatic page_reply_t apply_page_request(t_kind kind, int first, int count,
                                                       int align_log2);
        page_reply_t reply;
        longint      align_mask;
        int          p;
        int          start;
        int          run;
        reply.status  = ST_OK;
        reply.address = '0;
        reply.used    = 1'b0;
        case (kind)
            KIND_ALLOC: begin
                align_mask = 0;
                if (align_log2 > PAGE_SHIFT) begin
                    align_mask = (longint'(1) << (align_log2 - PAGE_SHIFT)) - 1;
                end
                if (count == 0) begin
                    reply.status = ST_ZERO_COUNT;
                end else begin
                    reply.status = ST_NO_RUN;
                    p     = 0;
                    run   = 0;
                    start = 0;
                    while (count <= PAGES && p < PAGES && run < count) begin
                        if (p % WORD_BITS == 0 && p + WORD_BITS <= PAGES
                                && &page_map[p / WORD_BITS]) begin
                            // skip a word with no free page in it
                            run = 0;
                            p += WORD_BITS;
                        end else if (page_is_used(p)) begin
                            run = 0;
                            p++;
                        end else if (run == 0 && (p & align_mask) != 0) begin
                            p++;
                        end else begin
                            if (run == 0) start = p;
                            run++;
                            p++;
                        end
                    end
                    if (count <= PAGES && run == count) begin
                        mark_pages(start, count, 1'b1);
                        reply.status  = ST_OK;
                        reply.address = ADDR_W'(longint'(start) << PAGE_SHIFT);
                        n_placed++;
                    end
                end
            end
            KIND_RELEASE, KIND_RESERVE: begin
                if (count == 0) begin
                    reply.status = ST_ZERO_COUNT;
                end else if (first + count > PAGES) begin
                    reply.status = ST_PAST_END;
                end else begin
                    mark_pages(first, count, kind == KIND_RESERVE);
                end
            end
            default: begin
                if (first >= PAGES) begin
                    reply.status = ST_PAST_END;
                end else begin
                    reply.used = page_is_used(first);
                end
            end
        endcase
        return reply;
    endfunction

    task automatic compare_field(string field, logic [ADDR_W-1:0] want,
                                 logic [ADDR_W-1:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t ns: %s expected 0x%0h got 0x%0h", $realtime, field, want, got);
            end
        end
    endtask

    always @(posedge i_clk) begin
        page_reply_t want;
        if (!i_rst_n) begin
            foreach (page_map[w]) page_map[w] = '1;
            expected_replies.delete();
        end else begin
            // a response never belongs to a request taken at the same edge
            if (i_rsp_valid && i_rsp_ready) begin
                if (expected_replies.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t ns: response with no request outstanding", $realtime);
                    end
                end else begin
                    want = expected_replies.pop_front();
                    compare_field("status", ADDR_W'(want.status), ADDR_W'(i_status));
                    compare_field("page_address", want.address, i_page_address);
                    compare_field("page_used", ADDR_W'(want.used), ADDR_W'(i_page_used));
                    n_answered <= n_answered + 1;
                end
            end
            if (i_req_valid && i_req_ready) begin
                expected_replies.push_back(apply_page_request(t_kind'(i_kind), i_page_index,
                                                              i_page_count, i_align_log2));
                n_issued <= n_issued + 1;
            end
        end
    end

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus for the bitmap page allocator. A directed opening walks the error
// checks, full-map and largest-alignment cases; random traffic then works a
// low window of pages with allocate, release, reserve and query requests,
// mixed with far-away ranges, rejected requests and random handshake gaps.
// ----------------------------------------------------------------------------
module tb import bpa_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_PAGES     = BPA_PAGE_COUNT;
    localparam int WINDOW      = 2048;
    localparam int N_ITEMS     = 550;
    localparam int PAUSE_AT    = 300;
    localparam int HOLD_AT     = 150;
    localparam int HOLD_CYCLES = 400;

    logic               clk;
    logic               rst_n        = 1'b0;
    logic               req_valid    = 1'b0;
    logic               req_ready;
    t_kind              kind         = KIND_ALLOC;
    logic [INDEX_W-1:0] page_index   = '0;
    logic [COUNT_W-1:0] page_count   = '0;
    logic [ALIGN_W-1:0] align_log2   = '0;
    logic               rsp_valid;
    logic               rsp_ready    = 1'b0;
    logic [1:0]         status;
    logic [ADDR_W-1:0]  page_address;
    logic               page_used;

    int fail_count;
    int pending;
    int checked;
    int placed;
    int n_sent      = 0;
    bit send_steady = 1'b0;
    bit recv_steady = 1'b0;

    bitmap_page_allocator_top #(.PAGE_COUNT(N_PAGES)) i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_req_valid    (req_valid),
        .o_req_ready    (req_ready),
        .i_kind         (kind),
        .i_page_index   (page_index),
        .i_page_count   (page_count),
        .i_align_log2   (align_log2),
        .o_rsp_valid    (rsp_valid),
        .i_rsp_ready    (rsp_ready),
        .o_status       (status),
        .o_page_address (page_address),
        .o_page_used    (page_used)
    );

    page_alloc_checker #(.PAGES(N_PAGES)) i_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_req_valid    (req_valid),
        .i_req_ready    (req_ready),
        .i_kind         (kind),
        .i_page_index   (page_index),
        .i_page_count   (page_count),
        .i_align_log2   (align_log2),
        .i_rsp_valid    (rsp_valid),
        .i_rsp_ready    (rsp_ready),
        .i_status       (status),
        .i_page_address (page_address),
        .i_page_used    (page_used),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked),
        .o_placed       (placed)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial begin
        #400_000_000;
        $display("status: fail");
        $finish;
    end

    task automatic send_request(t_kind k, int first, int count, int align);
        int gap;
        if ($urandom_range(0, 39) == 0) send_steady = !send_steady;
        gap = send_steady ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid  <= 1'b1;
        kind       <= k;
        page_index <= INDEX_W'(first);
        page_count <= COUNT_W'(count);
        align_log2 <= ALIGN_W'(align);
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        n_sent++;
    endtask

    // Hold new requests back until every reply is in.
    task automatic wait_for_replies();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic random_request();
        int pick;
        int first;
        int count;
        int align;
        int room;
        pick  = $urandom_range(0, 99);
        first = $urandom_range(0, WINDOW - 1);
        room  = WINDOW - first;
        align = $urandom_range(0, 28);
        if (pick < 30) begin
            count = $urandom_range(0, 99);
            if (count < 80) count = $urandom_range(1, 16);
            else if (count < 97) count = $urandom_range(1, 300);
            else count = $urandom_range(WINDOW + 1, N_PAGES);
            align = $urandom_range(0, 99);
            if (align < 60) align = $urandom_range(0, PAGE_SHIFT);
            else if (align < 92) align = $urandom_range(PAGE_SHIFT + 1, 20);
            else align = $urandom_range(21, 28);
            send_request(KIND_ALLOC, $urandom_range(0, 65535), count, align);
        end else if (pick < 55) begin
            send_request(KIND_RELEASE, first, $urandom_range(1, room < 64 ? room : 64), align);
        end else if (pick < 65) begin
            send_request(KIND_RESERVE, first, $urandom_range(1, room < 32 ? room : 32), align);
        end else if (pick < 80) begin
            if ($urandom_range(0, 9) < 3) first = $urandom_range(0, 65535);
            send_request(KIND_QUERY, first, $urandom_range(0, N_PAGES), align);
        end else if (pick < 86) begin
            // zero count wins over any range problem
            send_request(t_kind'($urandom_range(0, 2)), $urandom_range(0, 65535), 0, align);
        end else if (pick < 92) begin
            first = $urandom_range(1, 65535);
            send_request($urandom_range(0, 1) ? KIND_RELEASE : KIND_RESERVE, first,
                         $urandom_range(N_PAGES + 1 - first, N_PAGES), align);
        end else if (pick < 98) begin
            // free a stretch far above the window, look into it, take it back
            first = $urandom_range(WINDOW, 65535);
            room  = N_PAGES - first;
            count = $urandom_range(1, room < 256 ? room : 256);
            send_request(KIND_RELEASE, first, count, align);
            send_request(KIND_QUERY, first + $urandom_range(0, count - 1),
                         $urandom_range(0, N_PAGES), align);
            send_request(KIND_RESERVE, first, count, align);
        end else begin
            // open the whole map for one large allocation, then fence it off again
            send_request(KIND_RELEASE, 0, N_PAGES, align);
            send_request(KIND_ALLOC, $urandom_range(0, 65535),
                         $urandom_range(WINDOW + 1, N_PAGES), $urandom_range(0, 28));
            send_request(KIND_RESERVE, WINDOW, N_PAGES - WINDOW, align);
        end
    endtask

    // response side: random stalls, one long hold-off to back the block up
    initial begin
        int taken;
        int hold;
        taken = 0;
        @(posedge clk);
        rsp_ready <= 1'b1;
        forever begin
            @(posedge clk);
            if (rsp_valid && rsp_ready) begin
                taken++;
                if ($urandom_range(0, 39) == 0) recv_steady = !recv_steady;
                hold = recv_steady ? 0 : $urandom_range(0, 19);
                if (taken == HOLD_AT) hold = HOLD_CYCLES;
                if (hold > 0) begin
                    rsp_ready <= 1'b0;
                    repeat (hold) @(posedge clk);
                    rsp_ready <= 1'b1;
                end
            end
        end
    end

    initial begin
        int refill_at;
        bit paused;
        refill_at = 100;
        paused    = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        send_request(KIND_QUERY,   0,       N_PAGES, 28);
        send_request(KIND_ALLOC,   65535,   1,       0);
        send_request(KIND_ALLOC,   0,       0,       PAGE_SHIFT);
        send_request(KIND_RELEASE, 5,       0,       0);
        send_request(KIND_RESERVE, 65535,   0,       0);
        send_request(KIND_RELEASE, 65535,   2,       0);
        send_request(KIND_RESERVE, 1,       N_PAGES, 0);
        send_request(KIND_RELEASE, 0,       N_PAGES, 0);
        send_request(KIND_QUERY,   65535,   0,       0);
        send_request(KIND_ALLOC,   0,       N_PAGES, 28);
        send_request(KIND_RELEASE, 65535,   1,       0);
        // only page 0 sits on a 2^16-page boundary
        send_request(KIND_ALLOC,   0,       1,       28);
        send_request(KIND_RELEASE, 0,       1,       0);
        send_request(KIND_ALLOC,   0,       2,       28);
        send_request(KIND_ALLOC,   0,       1,       28);
        send_request(KIND_RELEASE, 4096,    4096,    0);
        send_request(KIND_ALLOC,   0,       16,      24);
        send_request(KIND_ALLOC,   0,       3,       13);
        send_request(KIND_QUERY,   4113,    0,       0);
        send_request(KIND_ALLOC,   0,       1,       5);
        send_request(KIND_RELEASE, 32768,   32768,   0);
        send_request(KIND_ALLOC,   0,       32768,   27);
        send_request(KIND_RESERVE, 0,       N_PAGES, 0);
        send_request(KIND_RELEASE, 0,       WINDOW,  0);

        while (n_sent < N_ITEMS) begin
            if (!paused && n_sent >= PAUSE_AT) begin
                wait_for_replies();
                paused = 1'b1;
            end
            if (n_sent >= refill_at) begin
                send_request(KIND_RELEASE, 0, WINDOW, $urandom_range(0, 28));
                refill_at += 100;
            end
            random_request();
        end

        wait_for_replies();
        repeat (100) @(posedge clk);
        $display("covered %0d requests of every kind, error checks, far ranges and stalls",
                 n_sent);
        $display("%0d replies compared, %0d allocations placed", checked, placed);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/bpa_pkg.sv
rtl/core/bpa_map_ram.sv
rtl/core/bpa_run_step.sv
rtl/core/bpa_word_mask.sv
rtl/core/bitmap_page_allocator_top.sv
sim/page_alloc_checker.sv
sim/tb.sv
